// ===== rtl/fbba_pkg.sv =====
// Shared types and constants for the free-block bitmap allocator.
// No dependencies; used by the top level and fbba_word_eval.
package fbba_pkg;

    localparam int NUM_BLOCKS_DEF  = 4096;
    localparam int BLOCK_BYTES_DEF = 4096;

    localparam int BITS_PER_WORD = 8;
    localparam int BIT_POS_W     = $clog2(BITS_PER_WORD);
    localparam int WORD_CNT_W    = $clog2(BITS_PER_WORD + 1);

    localparam int OPCODE_W      = 3;
    localparam int BLOCK_INDEX_W = 12;
    localparam int FILE_SIZE_W   = 25;

    localparam logic [OPCODE_W-1:0] OP_SET_USED = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_TEST     = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SPACE    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_FIND     = 3'd4;

    // Summary of one map word as seen by the scan.
    typedef struct packed {
        logic [WORD_CNT_W-1:0] free_cnt;
        logic                  any_free;
        logic [BIT_POS_W-1:0]  first_pos;
    } word_stat_t;

endpackage

// ===== rtl/free_block_bitmap_allocator_top.sv =====
// Top level of the free-block bitmap allocator: control sequencer around
// the occupancy map RAM. Depends on fbba_pkg, fbba_ram and fbba_word_eval.
//
// Usage: present opcode, block_index and file_size with start high; the item
// is taken at a clock edge where busy is low. Exactly one result per item
// appears on bit_value, has_space, free_index and found for one cycle, marked
// by done; the receiver cannot stall it, so it must take it then.
// The map holds eight blocks per RAM word (1 = used, 0 = free).
// Set, clear and test read the word, then modify and write it back: the
// result strobe is registered after the access state, and the next item
// can be taken in the cycle the strobe is shown.
// Space check and find-first-free scan the map one word per cycle through the
// single RAM read port. A space check reads every word, then multiplies and
// compares; find stops at the first word with a free block, or at the last
// word if none is free.
// After reset the block runs a clearing pass that writes every word to
// all-free; busy stays high meanwhile.
module free_block_bitmap_allocator_top #(
    parameter int NUM_BLOCKS  = fbba_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = fbba_pkg::BLOCK_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [fbba_pkg::OPCODE_W-1:0]      opcode,
    input  logic [fbba_pkg::BLOCK_INDEX_W-1:0] block_index,
    input  logic [fbba_pkg::FILE_SIZE_W-1:0]   file_size,
    output logic                               done,
    output logic                               bit_value,
    output logic                               has_space,
    output logic [fbba_pkg::BLOCK_INDEX_W-1:0] free_index,
    output logic                               found
);

    localparam int WW        = fbba_pkg::BITS_PER_WORD;
    localparam int MAP_WORDS = (NUM_BLOCKS + WW - 1) / WW;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int LAST_BITS = NUM_BLOCKS - (MAP_WORDS - 1) * WW;
    localparam int CW        = $clog2(NUM_BLOCKS + 1);
    localparam int BBW       = $clog2(BLOCK_BYTES + 1);
    localparam int PW0       = CW + BBW;
    localparam int PW        = (PW0 > fbba_pkg::FILE_SIZE_W) ? PW0 : fbba_pkg::FILE_SIZE_W;
    localparam int EW0       = (AW + fbba_pkg::BIT_POS_W > fbba_pkg::BLOCK_INDEX_W) ?
                               AW + fbba_pkg::BIT_POS_W : fbba_pkg::BLOCK_INDEX_W;
    localparam int EW        = EW0 + 1;

    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_SCAN,
        ST_MULT,
        ST_CMP
    } state_t;

    state_t                             state_reg;
    logic [fbba_pkg::OPCODE_W-1:0]      op_reg;
    logic [AW-1:0]                      addr_reg;
    logic [fbba_pkg::BIT_POS_W-1:0]     pos_reg;
    logic                               in_range_reg;
    logic [fbba_pkg::FILE_SIZE_W-1:0]   size_reg;
    logic [AW-1:0]                      issue_reg;
    logic                               issue_done_reg;
    logic                               data_valid_reg;
    logic [AW-1:0]                      data_addr_reg;
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic [PW-1:0]                      prod_reg;
    logic                               done_reg;
    logic                               bit_value_reg;
    logic                               has_space_reg;
    logic [fbba_pkg::BLOCK_INDEX_W-1:0] free_index_reg;
    logic                               found_reg;

    logic [EW-1:0]           blk_ext;
    logic                    blk_in_range;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [WW-1:0]           ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [WW-1:0]           ram_rdata;
    logic [WW-1:0]           bit_mask;
    logic                    data_last;
    fbba_pkg::word_stat_t    stat;
    logic [EW-1:0]           found_ext;

    assign blk_ext      = EW'(block_index);
    assign blk_in_range = blk_ext < EW'(NUM_BLOCKS);
    assign bit_mask     = WW'(1) << pos_reg;
    assign data_last    = data_addr_reg == LAST_WORD;
    assign count_next   = count_reg + CW'(stat.free_cnt);
    assign found_ext    = EW'({data_addr_reg, stat.first_pos});

    fbba_ram #(
        .WIDTH  (WW),
        .DEPTH  (MAP_WORDS),
        .ADDR_W (AW)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fbba_word_eval #(
        .LAST_BITS (LAST_BITS)
    ) u_eval (
        .word (ram_rdata),
        .last (data_last),
        .stat (stat)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = ram_rdata;
        ram_raddr = issue_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = issue_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                ram_raddr = blk_ext[AW+fbba_pkg::BIT_POS_W-1:fbba_pkg::BIT_POS_W];
            end
            ST_ACCESS:
            begin
                ram_we = in_range_reg &&
                         (op_reg == fbba_pkg::OP_SET_USED || op_reg == fbba_pkg::OP_CLEAR);
                ram_wdata = (op_reg == fbba_pkg::OP_SET_USED) ? (ram_rdata | bit_mask)
                                                              : (ram_rdata & ~bit_mask);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            issue_reg      <= '0;
            issue_done_reg <= 1'b0;
            data_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            bit_value_reg  <= 1'b0;
            has_space_reg  <= 1'b0;
            free_index_reg <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    issue_reg <= issue_reg + AW'(1);
                    if (issue_reg == LAST_WORD)
                    begin
                        issue_reg <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        op_reg         <= opcode;
                        addr_reg       <= blk_ext[AW+fbba_pkg::BIT_POS_W-1:fbba_pkg::BIT_POS_W];
                        pos_reg        <= blk_ext[fbba_pkg::BIT_POS_W-1:0];
                        in_range_reg   <= blk_in_range;
                        size_reg       <= file_size;
                        issue_reg      <= '0;
                        issue_done_reg <= 1'b0;
                        data_valid_reg <= 1'b0;
                        count_reg      <= '0;
                        if (opcode == fbba_pkg::OP_SPACE || opcode == fbba_pkg::OP_FIND)
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_ACCESS;
                        end
                    end
                end
                ST_ACCESS:
                begin
                    done_reg       <= 1'b1;
                    bit_value_reg  <= in_range_reg && (op_reg == fbba_pkg::OP_TEST) &&
                                      ((ram_rdata & bit_mask) != '0);
                    has_space_reg  <= 1'b0;
                    free_index_reg <= '0;
                    found_reg      <= 1'b0;
                    state_reg      <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    // One read issued per cycle; its word is judged in the cycle after.
                    data_valid_reg <= !issue_done_reg;
                    data_addr_reg  <= issue_reg;
                    if (!issue_done_reg)
                    begin
                        issue_reg <= issue_reg + AW'(1);
                        if (issue_reg == LAST_WORD)
                        begin
                            issue_done_reg <= 1'b1;
                        end
                    end
                    if (data_valid_reg)
                    begin
                        count_reg <= count_next;
                        if (op_reg == fbba_pkg::OP_FIND && (stat.any_free || data_last))
                        begin
                            done_reg       <= 1'b1;
                            bit_value_reg  <= 1'b0;
                            has_space_reg  <= 1'b0;
                            found_reg      <= stat.any_free;
                            free_index_reg <= stat.any_free ?
                                              found_ext[fbba_pkg::BLOCK_INDEX_W-1:0] : '0;
                            state_reg      <= ST_IDLE;
                        end
                        else if (op_reg != fbba_pkg::OP_FIND && data_last)
                        begin
                            state_reg <= ST_MULT;
                        end
                    end
                end
                ST_MULT:
                begin
                    // free_count >= ceil(size / B) holds exactly when free_count * B >= size.
                    prod_reg  <= PW'(count_reg) * PW'(BLOCK_BYTES);
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    done_reg       <= 1'b1;
                    bit_value_reg  <= 1'b0;
                    has_space_reg  <= prod_reg >= PW'(size_reg);
                    free_index_reg <= '0;
                    found_reg      <= 1'b0;
                    state_reg      <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy       = state_reg != ST_IDLE;
    assign done       = done_reg;
    assign bit_value  = bit_value_reg;
    assign has_space  = has_space_reg;
    assign free_index = free_index_reg;
    assign found      = found_reg;

endmodule

// ===== rtl/fbba_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module fbba_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/fbba_word_eval.sv =====
// Counts the free blocks of one map word and finds the lowest free one.
// Depends on fbba_pkg.
module fbba_word_eval #(
    parameter int LAST_BITS = fbba_pkg::BITS_PER_WORD
) (
    input  logic [fbba_pkg::BITS_PER_WORD-1:0] word,
    input  logic                               last,
    output fbba_pkg::word_stat_t               stat
);

    localparam logic [fbba_pkg::BITS_PER_WORD-1:0] LAST_MASK =
        fbba_pkg::BITS_PER_WORD'((17'd1 << LAST_BITS) - 17'd1);

    logic [fbba_pkg::BITS_PER_WORD-1:0] free_bits;

    // Bits past the last block of the device are neither counted nor found.
    assign free_bits = ~word & (last ? LAST_MASK : {fbba_pkg::BITS_PER_WORD{1'b1}});

    always_comb
    begin
        stat.free_cnt  = '0;
        stat.first_pos = '0;
        stat.any_free  = |free_bits;
        for (int i = 0; i < fbba_pkg::BITS_PER_WORD; i++)
        begin
            stat.free_cnt = stat.free_cnt + fbba_pkg::WORD_CNT_W'(free_bits[i]);
        end
        for (int i = fbba_pkg::BITS_PER_WORD - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                stat.first_pos = fbba_pkg::BIT_POS_W'(i);
            end
        end
    end

endmodule
